[sv/modexp_miller_rabin_round_unit_defines.svh]
// Assertion macros used by the round unit RTL.
`ifndef MODEXP_MILLER_RABIN_ROUND_UNIT_DEFINES_SVH
`define MODEXP_MILLER_RABIN_ROUND_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mmr_pkg.sv]
package mmr_pkg;

  localparam int WIDTH_DEFAULT = 64;

  localparam logic CMD_POW     = 1'b0;
  localparam logic CMD_WITNESS = 1'b1;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_DBL,
    MUL_ADD
  } mmr_mul_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ODD,
    S_ARED,
    S_AWAIT,
    S_BRED,
    S_BWAIT,
    S_POW,
    S_MULR,
    S_SQ,
    S_MULB,
    S_POWDONE,
    S_WLOOP,
    S_WSQ,
    S_DONE
  } mmr_state_t;

endpackage

[sv/mmr_modmul.sv]
module mmr_modmul #(
  parameter int WIDTH = mmr_pkg::WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic [WIDTH-1:0] op_m,
  output logic             done,
  output logic [WIDTH-1:0] result
);
  import mmr_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  mmr_mul_state_t state_r, state_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  logic [WIDTH-1:0] addend;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   sum_red;
  logic [WIDTH-1:0] mod_sum;

  // One modular addition per cycle: the doubling step or the add step.
  assign addend  = (state_r == MUL_ADD) ? a_r : r_r;
  assign sum     = {1'b0, r_r} + {1'b0, addend};
  assign sum_red = sum - {1'b0, m_r};
  assign mod_sum = (sum >= {1'b0, m_r}) ? sum_red[WIDTH-1:0] : sum[WIDTH-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MUL_IDLE: begin
        if (start) begin
          state_nxt = MUL_DBL;
        end
      end
      MUL_DBL: begin
        if (b_r[WIDTH-1]) begin
          state_nxt = MUL_ADD;
        end else if (cnt_r == '0) begin
          state_nxt = MUL_IDLE;
        end
      end
      MUL_ADD: begin
        state_nxt = (cnt_r == '0) ? MUL_IDLE : MUL_DBL;
      end
      default: state_nxt = MUL_IDLE;
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    case (state_r)
      MUL_IDLE: begin
        if (start) begin
          a_nxt   = op_a;
          b_nxt   = op_b;
          m_nxt   = op_m;
          r_nxt   = '0;
          cnt_nxt = CNT_W'(WIDTH - 1);
        end
      end
      MUL_DBL: begin
        r_nxt = mod_sum;
        if (!b_r[WIDTH-1]) begin
          if (cnt_r == '0) begin
            done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
            b_nxt   = b_r << 1;
          end
        end
      end
      MUL_ADD: begin
        r_nxt = mod_sum;
        if (cnt_r == '0) begin
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          b_nxt   = b_r << 1;
        end
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MUL_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

endmodule

[sv/modexp_miller_rabin_round_unit.sv]
// Channel   Handshake              Ports
// command   start high, busy low   in_cmd, in_base, in_exponent, in_modulus
// result    out_valid for 1 cycle  out_value, out_probable_prime, out_error
//
// One transaction at a time; busy stays high from acceptance to the result strobe.
// Every modular multiplication runs on the shared shift-add unit and ends with its done strobe.
// A power takes one reduction plus up to two multiplications per exponent bit;
// a witness round adds up to WIDTH squarings.
// Reset is synchronous and active low and returns the unit to idle.
// The result is presented for exactly one cycle and cannot be stalled.
module modexp_miller_rabin_round_unit #(
  parameter int WIDTH = mmr_pkg::WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_cmd,
  input  logic [WIDTH-1:0] in_base,
  input  logic [WIDTH-1:0] in_exponent,
  input  logic [WIDTH-1:0] in_modulus,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_value,
  output logic             out_probable_prime,
  output logic             out_error
);
  import mmr_pkg::*;
  `include "modexp_miller_rabin_round_unit_defines.svh"

  mmr_state_t state_r, state_nxt;
  logic             cmd_r, cmd_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] pm1_r, pm1_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] t_r, t_nxt;
  logic [WIDTH-1:0] value_r, value_nxt;
  logic             pp_r, pp_nxt;
  logic             err_r, err_nxt;

  logic             mul_start;
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH-1:0] mul_b;
  logic [WIDTH-1:0] mul_m;
  logic             mul_done;
  logic [WIDTH-1:0] mul_res;

  logic             accept;
  logic [WIDTH-1:0] one_m;
  logic [WIDTH-1:0] in_pm1;
  logic [WIDTH-1:0] e_shift;
  logic             wit_go;

  assign accept  = start && !busy;
  assign one_m   = (m_r == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign in_pm1  = in_modulus - WIDTH'(1);
  assign e_shift = e_r >> 1;
  assign wit_go  = (t_r != pm1_r) && (r_r != WIDTH'(1)) && (r_r != pm1_r);

  mmr_modmul #(
    .WIDTH(WIDTH)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .op_m  (mul_m),
    .done  (mul_done),
    .result(mul_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_POW) begin
            state_nxt = (in_modulus == '0) ? S_DONE : S_BRED;
          end else if (in_modulus < WIDTH'(3) || !in_modulus[0]) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ODD;
          end
        end
      end
      S_ODD: begin
        if (d_r[0]) begin
          state_nxt = (a_r >= m_r) ? S_ARED : S_BRED;
        end
      end
      S_ARED:  state_nxt = S_AWAIT;
      S_AWAIT: state_nxt = mul_done ? S_BRED : S_AWAIT;
      S_BRED:  state_nxt = S_BWAIT;
      S_BWAIT: state_nxt = mul_done ? S_POW : S_BWAIT;
      S_POW: begin
        if (e_r == '0) begin
          state_nxt = S_POWDONE;
        end else begin
          state_nxt = e_r[0] ? S_MULR : S_SQ;
        end
      end
      S_MULR:  state_nxt = mul_done ? S_SQ : S_MULR;
      S_SQ:    state_nxt = (e_shift == '0) ? S_POWDONE : S_MULB;
      S_MULB:  state_nxt = mul_done ? S_POW : S_MULB;
      S_POWDONE: state_nxt = (cmd_r == CMD_POW) ? S_DONE : S_WLOOP;
      S_WLOOP: state_nxt = wit_go ? S_WSQ : S_DONE;
      S_WSQ:   state_nxt = mul_done ? S_WLOOP : S_WSQ;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt   = cmd_r;
    a_nxt     = a_r;
    e_nxt     = e_r;
    m_nxt     = m_r;
    pm1_nxt   = pm1_r;
    d_nxt     = d_r;
    r_nxt     = r_r;
    t_nxt     = t_r;
    value_nxt = value_r;
    pp_nxt    = pp_r;
    err_nxt   = err_r;
    mul_start = 1'b0;
    mul_a     = r_r;
    mul_b     = a_r;
    mul_m     = m_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          a_nxt     = in_base;
          e_nxt     = in_exponent;
          m_nxt     = in_modulus;
          pm1_nxt   = in_pm1;
          d_nxt     = in_pm1 >> 1;
          value_nxt = '0;
          err_nxt   = (in_cmd == CMD_POW) && (in_modulus == '0);
          pp_nxt    = (in_cmd == CMD_WITNESS) && (in_modulus == WIDTH'(2));
        end
      end
      S_ODD: begin
        if (d_r[0]) begin
          e_nxt = d_r;
        end else begin
          d_nxt = d_r >> 1;
        end
      end
      S_ARED: begin
        mul_start = 1'b1;
        mul_a     = WIDTH'(1);
        mul_b     = a_r;
        mul_m     = pm1_r;
      end
      S_AWAIT: begin
        if (mul_done) begin
          a_nxt = mul_res + WIDTH'(1);
        end
      end
      S_BRED: begin
        mul_start = 1'b1;
        mul_a     = one_m;
        mul_b     = a_r;
      end
      S_BWAIT: begin
        if (mul_done) begin
          a_nxt = mul_res;
          r_nxt = one_m;
        end
      end
      S_POW: begin
        if (e_r != '0 && e_r[0]) begin
          mul_start = 1'b1;
        end
      end
      S_MULR: begin
        if (mul_done) begin
          r_nxt = mul_res;
        end
      end
      S_SQ: begin
        e_nxt = e_shift;
        if (e_shift != '0) begin
          mul_start = 1'b1;
          mul_a     = a_r;
        end
      end
      S_MULB: begin
        if (mul_done) begin
          a_nxt = mul_res;
        end
      end
      S_POWDONE: begin
        if (cmd_r == CMD_POW) begin
          value_nxt = r_r;
        end else begin
          t_nxt = d_r;
        end
      end
      S_WLOOP: begin
        if (wit_go) begin
          mul_start = 1'b1;
          mul_b     = r_r;
          t_nxt     = t_r << 1;
        end else begin
          pp_nxt = (r_r == pm1_r) || t_r[0];
        end
      end
      S_WSQ: begin
        if (mul_done) begin
          r_nxt = mul_res;
        end
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    a_r     <= a_nxt;
    e_r     <= e_nxt;
    m_r     <= m_nxt;
    pm1_r   <= pm1_nxt;
    d_r     <= d_nxt;
    r_r     <= r_nxt;
    t_r     <= t_nxt;
    value_r <= value_nxt;
    pp_r    <= pp_nxt;
    err_r   <= err_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_DONE);
  assign out_value          = value_r;
  assign out_probable_prime = pp_r;
  assign out_error          = err_r;

  `MMR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy,
    "accept did not raise busy")
  `MMR_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && out_error, out_value == '0,
    "error with nonzero value")
  `MMR_ASSERT_SAME(a_pp_no_err, clk, rst_n, out_valid && out_probable_prime, !out_error,
    "prime flag with error")
  `MMR_ASSERT_SAME(a_done_wait, clk, rst_n, mul_done,
    state_r == S_AWAIT || state_r == S_BWAIT || state_r == S_MULR ||
    state_r == S_MULB || state_r == S_WSQ,
    "multiplier done outside a wait state")

endmodule
